// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int DEQ_DEPTH  = 64;
  localparam int DEQ_DATA_W = 32;

  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_READ       = 3'd4;
  localparam logic [2:0] MODE_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [5:0]         index;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [6:0]         count;
  } deq_out_t;

endpackage

// ===== rtl/deq_ram.sv =====
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// A result goes through the RAM read register, then the output register.
// Throughput: one item per cycle while in_stall is low; the ring RAM sees at most one write or one read per item.
// Writes land at the clock edge of the accepting cycle, so a following read sees them.
// Reset (synchronous, rst_n low): queue empty, front pointer zero, pipeline empty.
// RAM contents are not cleared; only entries written by a push are ever read.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  deq_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_out_t out_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 6) ? CW : 6) + 1;

  logic [PW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          s1_valid_r, s1_take_r;
  logic [1:0]    s1_status_r;
  logic [6:0]    s1_count_r;
  logic          out_valid_r;
  deq_out_t      out_r;

  logic          accept, s1_move;
  logic          is_full, is_empty;
  logic [XW-1:0] offset, sum;
  logic [PW-1:0] slot, front_dec, front_inc, addr;
  logic          op_we, op_re, op_take;
  logic [1:0]    op_status;
  logic [DEQ_DATA_W-1:0] rdata;

  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  assign front_dec = (front_r == '0) ? PW'(DEPTH - 1) : front_r - PW'(1);
  assign front_inc = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + PW'(1);

  // one ring adder serves back-end pushes, back-end pops and indexed reads
  always_comb begin
    unique case (in_item.mode)
      MODE_PUSH_BACK: offset = XW'(count_r);
      MODE_POP_BACK:  offset = XW'(count_r) - XW'(1);
      MODE_READ:      offset = XW'(in_item.index);
      default:        offset = '0;
    endcase
  end

  assign sum  = XW'(front_r) + offset;
  assign slot = (sum >= XW'(DEPTH)) ? PW'(sum - XW'(DEPTH)) : PW'(sum);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    op_we     = 1'b0;
    op_re     = 1'b0;
    op_take   = 1'b0;
    op_status = ST_OK;
    addr      = slot;
    unique case (in_item.mode)
      MODE_PUSH_BACK: begin
        if (is_full) begin
          op_status = ST_FULL;
        end else begin
          op_we     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (is_full) begin
          op_status = ST_FULL;
        end else begin
          op_we     = 1'b1;
          addr      = front_dec;
          front_nxt = front_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (is_empty) begin
          op_status = ST_EMPTY;
        end else begin
          op_re     = 1'b1;
          op_take   = 1'b1;
          addr      = front_r;
          front_nxt = front_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (is_empty) begin
          op_status = ST_EMPTY;
        end else begin
          op_re     = 1'b1;
          op_take   = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      MODE_READ: begin
        if (XW'(in_item.index) >= XW'(count_r)) begin
          op_status = ST_RANGE;
        end else begin
          op_re   = 1'b1;
          op_take = 1'b1;
        end
      end
      MODE_CLEAR: begin
        front_nxt = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  deq_ram #(
    .WIDTH (DEQ_DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && op_we),
    .waddr (addr),
    .wdata (in_item.value),
    .re    (accept && op_re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_take_r   <= op_take;
      s1_status_r <= op_status;
      s1_count_r  <= 7'(count_nxt);
    end
    if (s1_move) begin
      out_r.data   <= s1_take_r ? $signed(rdata) : '0;
      out_r.status <= s1_status_r;
      out_r.count  <= s1_count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/deq_chk.sv =====
module deq_chk
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input deq_out_t out_item
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  // input backs up only behind a stalled full output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.data != '0) |-> out_item.status == ST_OK)
    else $error("data returned with error status");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |-> out_item.count == '0)
    else $error("empty status with non-zero count");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_item.count) <= DEPTH)
    else $error("count above depth");

endmodule

bind double_ended_queue_unit deq_chk #(.DEPTH(DEPTH)) u_deq_chk (.*);
